/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// No dependencies; every macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge while reset is released.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// The condition must never be true while reset is released.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* hw/rtl/lpss_pkg.sv */
// Shared types and constants of the local-preferring server selector.
// Used by the controller, the datapath and the top level.
package lpss_pkg;

  localparam int unsigned MAX_SERVERS_DEF = 16;
  localparam logic [31:0] LOCAL_ADDR_RESET = 32'h7F00_0001;

  localparam logic [2:0] ACT_ADD       = 3'd0;
  localparam logic [2:0] ACT_REMOVE    = 3'd1;
  localparam logic [2:0] ACT_MARK_FAIL = 3'd2;
  localparam logic [2:0] ACT_MARK_OK   = 3'd3;
  localparam logic [2:0] ACT_NEXT_OK   = 3'd4;
  localparam logic [2:0] ACT_NEXT_FAIL = 3'd5;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_HEALTHY = 2'd1;
  localparam logic [1:0] ST_NO_FAILED  = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  localparam logic CFG_PREFER_LOCAL = 1'b0;
  localparam logic CFG_LOCAL_ADDR   = 1'b1;

  typedef enum logic [1:0] {
    LIST_H,
    LIST_F,
    LIST_L
  } list_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_IDX_CLR,
    OP_RD,
    OP_CMP,
    OP_RD_NEXT,
    OP_WR_SHIFT,
    OP_DEC,
    OP_PUSH,
    OP_PICK_RD,
    OP_PICK_CAP,
    OP_STATUS
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    list_e      sel;
    logic [1:0] st;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       match;
    logic       at_end;
    logic       at_last;
    logic       h_empty;
    logic       f_empty;
    logic       l_empty;
    logic       full;
    logic       key_local;
    logic       prefer;
  } stat_t;

endpackage

/* hw/rtl/lpss_datapath.sv */
// Datapath of the server selector: list memories, lengths, pointers, registers.
// Executes one command from the controller per cycle; depends on lpss_pkg.
module lpss_datapath import lpss_pkg::*; #(
  parameter int unsigned MaxServers = MAX_SERVERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [2:0]  action_i,
  input  logic [31:0] addr_i,
  input  logic [15:0] port_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output logic [1:0]  status_o,
  output logic [31:0] res_addr_o,
  output logic [15:0] res_port_o,
  output logic [4:0]  hcnt_o,
  output logic [4:0]  fcnt_o,
  output logic [4:0]  lcnt_o
);

  localparam int unsigned IW = (MaxServers > 1) ? $clog2(MaxServers) : 1;
  localparam int unsigned CW = $clog2(MaxServers + 1);
  localparam logic [CW-1:0] MaxC = CW'(MaxServers);

  logic [47:0] hmem [MaxServers];
  logic [47:0] fmem [MaxServers];
  logic [47:0] lmem [MaxServers];
  logic [47:0] rd_q;

  logic [CW-1:0] hlen_q, flen_q, llen_q, hptr_q, fptr_q, lptr_q, idx_q;
  logic [CW-1:0] hlen_d, flen_d, llen_d, hptr_d, fptr_d, lptr_d, idx_d;
  logic [CW-1:0] len_sel, ptr_sel, idx_inc, eff_ptr, eff_inc, ptr_new;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [47:0]   wr_data;
  logic          wr_en;
  logic [CW:0]   total;

  logic [47:0] key_q, picked_q;
  logic [2:0]  action_q;
  logic [1:0]  status_q;
  logic        prefer_q;
  logic [31:0] laddr_q;

  always_comb begin
    case (cmd_i.sel)
      LIST_F:  begin len_sel = flen_q; ptr_sel = fptr_q; end
      LIST_L:  begin len_sel = llen_q; ptr_sel = lptr_q; end
      default: begin len_sel = hlen_q; ptr_sel = hptr_q; end
    endcase
    idx_inc = idx_q + 1'b1;
    eff_ptr = (ptr_sel >= len_sel) ? '0 : ptr_sel;
    eff_inc = eff_ptr + 1'b1;
    ptr_new = (eff_inc == len_sel) ? '0 : eff_inc;
    case (cmd_i.op)
      OP_RD_NEXT: rd_addr = idx_inc[IW-1:0];
      OP_PICK_RD: rd_addr = eff_ptr[IW-1:0];
      default:    rd_addr = idx_q[IW-1:0];
    endcase
    wr_en   = 1'b0;
    wr_addr = idx_q[IW-1:0];
    wr_data = rd_q;
    if (cmd_i.op == OP_WR_SHIFT) begin
      wr_en = 1'b1;
    end else if (cmd_i.op == OP_PUSH && len_sel < MaxC) begin
      wr_en   = 1'b1;
      wr_addr = len_sel[IW-1:0];
      wr_data = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case (cmd_i.sel)
        LIST_F:  fmem[wr_addr] <= wr_data;
        LIST_L:  lmem[wr_addr] <= wr_data;
        default: hmem[wr_addr] <= wr_data;
      endcase
    end
    case (cmd_i.sel)
      LIST_F:  rd_q <= fmem[rd_addr];
      LIST_L:  rd_q <= lmem[rd_addr];
      default: rd_q <= hmem[rd_addr];
    endcase
  end

  always_comb begin
    hlen_d = hlen_q; flen_d = flen_q; llen_d = llen_q;
    hptr_d = hptr_q; fptr_d = fptr_q; lptr_d = lptr_q;
    idx_d  = idx_q;
    case (cmd_i.op)
      OP_IDX_CLR:  idx_d = '0;
      OP_CMP:      if (rd_q != key_q) idx_d = idx_inc;
      OP_WR_SHIFT: idx_d = idx_inc;
      OP_DEC: begin
        case (cmd_i.sel)
          LIST_F:  flen_d = flen_q - 1'b1;
          LIST_L:  llen_d = llen_q - 1'b1;
          default: hlen_d = hlen_q - 1'b1;
        endcase
      end
      OP_PUSH: begin
        if (len_sel < MaxC) begin
          case (cmd_i.sel)
            LIST_F:  flen_d = flen_q + 1'b1;
            LIST_L:  llen_d = llen_q + 1'b1;
            default: hlen_d = hlen_q + 1'b1;
          endcase
        end
      end
      OP_PICK_RD: begin
        case (cmd_i.sel)
          LIST_F:  fptr_d = ptr_new;
          LIST_L:  lptr_d = ptr_new;
          default: hptr_d = ptr_new;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hlen_q   <= '0;
      flen_q   <= '0;
      llen_q   <= '0;
      hptr_q   <= '0;
      fptr_q   <= '0;
      lptr_q   <= '0;
      idx_q    <= '0;
      prefer_q <= 1'b0;
      laddr_q  <= LOCAL_ADDR_RESET;
    end else begin
      hlen_q <= hlen_d;
      flen_q <= flen_d;
      llen_q <= llen_d;
      hptr_q <= hptr_d;
      fptr_q <= fptr_d;
      lptr_q <= lptr_d;
      idx_q  <= idx_d;
      if (cfg_we_i && cfg_idx_i == CFG_PREFER_LOCAL) prefer_q <= cfg_data_i[0];
      if (cfg_we_i && cfg_idx_i == CFG_LOCAL_ADDR) laddr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        key_q    <= {addr_i, port_i};
        action_q <= action_i;
        status_q <= ST_OK;
        picked_q <= '0;
      end
      OP_PICK_CAP: picked_q <= rd_q;
      OP_STATUS:   status_q <= cmd_i.st;
      default: ;
    endcase
  end

  assign total = {1'b0, hlen_q} + {1'b0, flen_q};

  always_comb begin
    stat_o.action    = action_q;
    stat_o.match     = (rd_q == key_q);
    stat_o.at_end    = (idx_q == len_sel);
    stat_o.at_last   = (idx_inc >= len_sel);
    stat_o.h_empty   = (hlen_q == '0);
    stat_o.f_empty   = (flen_q == '0);
    stat_o.l_empty   = (llen_q == '0);
    stat_o.full      = (total >= {1'b0, MaxC});
    stat_o.key_local = (key_q[47:16] == laddr_q);
    stat_o.prefer    = prefer_q;
  end

  assign status_o   = status_q;
  assign res_addr_o = picked_q[47:16];
  assign res_port_o = picked_q[15:0];
  assign hcnt_o     = 5'(hlen_q);
  assign fcnt_o     = 5'(flen_q);
  assign lcnt_o     = 5'(llen_q);

endmodule

/* hw/rtl/lpss_ctrl.sv */
// Controller of the server selector: sequences searches, erases, pushes, picks.
// Drives datapath commands and the stream handshakes; depends on lpss_pkg.
module lpss_ctrl import lpss_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_FCHK = 5'd2;
  localparam logic [4:0] S_FCMP = 5'd3;
  localparam logic [4:0] S_ECHK = 5'd4;
  localparam logic [4:0] S_EWR  = 5'd5;
  localparam logic [4:0] S_PICK = 5'd6;
  localparam logic [4:0] S_PCAP = 5'd7;
  localparam logic [4:0] S_A1   = 5'd8;
  localparam logic [4:0] S_A2   = 5'd9;
  localparam logic [4:0] S_A3   = 5'd10;
  localparam logic [4:0] S_R1   = 5'd11;
  localparam logic [4:0] S_R2   = 5'd12;
  localparam logic [4:0] S_R3   = 5'd13;
  localparam logic [4:0] S_M1   = 5'd14;
  localparam logic [4:0] S_M2   = 5'd15;
  localparam logic [4:0] S_H1   = 5'd16;
  localparam logic [4:0] S_H2   = 5'd17;
  localparam logic [4:0] S_OUT  = 5'd18;

  logic [4:0] state_q, state_d, ret_q, ret_d;
  list_e      sel_q, sel_d;
  logic       found_q, found_d;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    sel_d     = sel_q;
    found_d   = found_q;
    cmd_o.op  = OP_NOP;
    cmd_o.sel = sel_q;
    cmd_o.st  = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_FCHK;
        cmd_o.op = OP_IDX_CLR;
        case (stat_i.action)
          ACT_ADD:       begin sel_d = LIST_H; ret_d = S_A1; end
          ACT_REMOVE:    begin sel_d = LIST_H; ret_d = S_R1; end
          ACT_MARK_FAIL: begin sel_d = LIST_H; ret_d = S_M1; end
          ACT_MARK_OK:   begin sel_d = LIST_F; ret_d = S_H1; end
          ACT_NEXT_OK: begin
            state_d = S_PICK;
            if (stat_i.prefer && !stat_i.l_empty) begin
              sel_d = LIST_L;
            end else if (!stat_i.h_empty) begin
              sel_d = LIST_H;
            end else begin
              cmd_o.op = OP_STATUS;
              cmd_o.st = ST_NO_HEALTHY;
              state_d  = S_OUT;
            end
          end
          ACT_NEXT_FAIL: begin
            state_d = S_PICK;
            sel_d   = LIST_F;
            if (stat_i.f_empty) begin
              cmd_o.op = OP_STATUS;
              cmd_o.st = ST_NO_FAILED;
              state_d  = S_OUT;
            end
          end
          default: state_d = S_OUT;
        endcase
      end
      S_FCHK: begin
        if (stat_i.at_end) begin
          found_d = 1'b0;
          state_d = ret_q;
        end else begin
          cmd_o.op = OP_RD;
          state_d  = S_FCMP;
        end
      end
      S_FCMP: begin
        cmd_o.op = OP_CMP;
        if (stat_i.match) begin
          found_d = 1'b1;
          state_d = ret_q;
        end else begin
          state_d = S_FCHK;
        end
      end
      S_ECHK: begin
        if (stat_i.at_last) begin
          cmd_o.op = OP_DEC;
          state_d  = ret_q;
        end else begin
          cmd_o.op = OP_RD_NEXT;
          state_d  = S_EWR;
        end
      end
      S_EWR: begin
        cmd_o.op = OP_WR_SHIFT;
        state_d  = S_ECHK;
      end
      S_PICK: begin
        cmd_o.op = OP_PICK_RD;
        state_d  = S_PCAP;
      end
      S_PCAP: begin
        cmd_o.op = OP_PICK_CAP;
        state_d  = S_OUT;
      end
      S_A1: begin
        if (found_q) begin
          state_d = S_OUT;
        end else begin
          cmd_o.op = OP_IDX_CLR;
          sel_d    = LIST_F;
          ret_d    = S_A2;
          state_d  = S_FCHK;
        end
      end
      S_A2: begin
        state_d = S_OUT;
        if (!found_q) begin
          if (stat_i.full) begin
            cmd_o.op = OP_STATUS;
            cmd_o.st = ST_FULL;
          end else begin
            cmd_o.op  = OP_PUSH;
            cmd_o.sel = LIST_H;
            state_d   = S_A3;
          end
        end
      end
      S_A3: begin
        if (stat_i.key_local) begin
          cmd_o.op  = OP_PUSH;
          cmd_o.sel = LIST_L;
        end
        state_d = S_OUT;
      end
      S_R1: begin
        if (found_q) begin
          ret_d   = S_R2;
          state_d = S_ECHK;
        end else begin
          cmd_o.op = OP_IDX_CLR;
          sel_d    = LIST_F;
          ret_d    = S_R3;
          state_d  = S_FCHK;
        end
      end
      S_R2: begin
        cmd_o.op = OP_IDX_CLR;
        sel_d    = LIST_L;
        ret_d    = S_R3;
        state_d  = S_FCHK;
      end
      S_R3: begin
        ret_d   = S_OUT;
        state_d = found_q ? S_ECHK : S_OUT;
      end
      S_M1: begin
        ret_d   = S_M2;
        state_d = found_q ? S_ECHK : S_OUT;
      end
      S_M2: begin
        cmd_o.op  = OP_PUSH;
        cmd_o.sel = LIST_F;
        state_d   = S_R2;
      end
      S_H1: begin
        ret_d   = S_H2;
        state_d = found_q ? S_ECHK : S_OUT;
      end
      S_H2: begin
        cmd_o.op  = OP_PUSH;
        cmd_o.sel = LIST_H;
        state_d   = S_A3;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_OUT;
      sel_q   <= LIST_H;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      sel_q   <= sel_d;
      found_q <= found_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

/* hw/rtl/local_preferring_server_selector.sv */
// Local-preferring server selector keeps healthy, failed and local lists of
// server endpoints in three memories and answers each request with one result.
// One request is handled at a time; its cost is set by the single read port,
// which each entry searched or shifted must pass through. Depends on
// lpss_pkg, lpss_ctrl and lpss_datapath.
module local_preferring_server_selector import lpss_pkg::*; #(
  parameter int unsigned MaxServers = MAX_SERVERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action [2:0], coord_address [34:3], coord_port [50:35]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status [1:0], result_address [33:2], result_port [49:34],
  // healthy_count [54:50], failed_count [59:55], local_count [64:60]
  output logic [71:0] m_axis_tdata
);

  cmd_t        cmd;
  stat_t       stat;
  logic [1:0]  status;
  logic [31:0] res_addr;
  logic [15:0] res_port;
  logic [4:0]  hcnt, fcnt, lcnt;

  lpss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lpss_datapath #(.MaxServers(MaxServers)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .action_i   (s_axis_tdata[2:0]),
    .addr_i     (s_axis_tdata[34:3]),
    .port_i     (s_axis_tdata[50:35]),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .status_o   (status),
    .res_addr_o (res_addr),
    .res_port_o (res_port),
    .hcnt_o     (hcnt),
    .fcnt_o     (fcnt),
    .lcnt_o     (lcnt)
  );

  assign m_axis_tdata = {7'd0, lcnt, fcnt, hcnt, res_port, res_addr, status};

endmodule

/* hw/rtl/lpss_checker.sv */
// Port-level checker of the server selector, bound to the top level.
// Uses assert_macros.svh and lpss_pkg.
`include "assert_macros.svh"

module lpss_checker import lpss_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  `ASSERT_NEVER(a_one_at_a_time, clk_i, rst_ni, m_axis_tvalid && s_axis_tready)
  `ASSERT_AT(a_result_once, clk_i, rst_ni, (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
  `ASSERT_AT(a_no_pick_zero, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[1:0] != ST_OK) |-> (m_axis_tdata[49:2] == '0))

endmodule

bind local_preferring_server_selector lpss_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
